### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/csq_pkg.sv
// Shared constants, codes and types of the semaphore bank with wait queues.
// No dependencies; imported by every module of the block but csq_ram.
package csq_pkg;

    localparam int NUM_SEMAPHORES = 4;
    localparam int NUM_PROCESSES  = 16;
    localparam int QUEUE_DEPTH    = 16;

    localparam int NUM_INIT_REGS  = 4;
    localparam int INIT_W         = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int SEM_IN_W       = 2;
    localparam int ID_W           = 4;
    localparam int COUNT_W        = 5;
    localparam int STATUS_W       = 2;

    localparam int SEM_W   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QADDR_W = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH);

    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -COUNT_W'(16);
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = COUNT_W'(15);

    localparam logic OP_P = 1'b0;
    localparam logic OP_V = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Request held while the read of both memories is in flight.
    typedef struct packed {
        logic              absent;
        logic              op;
        logic [SEM_W-1:0]  sem;
        logic [ID_W-1:0]   caller;
        logic [HEAD_W-1:0] head;
        logic [LEN_W-1:0]  len;
    } t_req;

    // Decision of the update logic for one request.
    typedef struct packed {
        logic                        cnt_we;
        logic signed [COUNT_W-1:0]   cnt;
        logic                        enq;
        logic                        deq;
        logic                        blocked;
        logic [STATUS_W-1:0]         status;
    } t_upd;

    function automatic logic [INIT_W-1:0] init_reset_value(input int k);
        return (k == 0) ? INIT_W'(1) : INIT_W'(0);
    endfunction

endpackage

### rtl/csq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module csq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/csq_alu.sv
// Update logic: decides count, queue push/pop and status for one request.
// Depends on csq_pkg.
module csq_alu import csq_pkg::*; (
    input  t_req                      i_req,
    input  logic signed [COUNT_W-1:0] i_count,
    output t_upd                      o_upd
);

    logic signed [COUNT_W-1:0] w_dec;
    logic signed [COUNT_W-1:0] w_inc;

    assign w_dec = i_count - COUNT_W'(1);
    assign w_inc = i_count + COUNT_W'(1);

    always_comb begin
        o_upd         = '0;
        o_upd.cnt     = i_count;
        if (i_req.absent) begin
            o_upd.cnt = '0;
        end else if (i_req.op == OP_P) begin
            // Block path needs a free queue slot; check it before the floor.
            if ((i_count <= 0) && (i_req.len >= LEN_W'(QUEUE_DEPTH))) begin
                o_upd.status = STATUS_FULL;
            end else if (i_count == COUNT_MIN) begin
                o_upd.status = STATUS_SAT;
            end else begin
                o_upd.cnt_we  = 1'b1;
                o_upd.cnt     = w_dec;
                o_upd.enq     = (w_dec < 0);
                o_upd.blocked = (w_dec < 0);
            end
        end else begin
            if (i_count == COUNT_MAX) begin
                o_upd.status = STATUS_SAT;
            end else begin
                o_upd.cnt_we = 1'b1;
                o_upd.cnt    = w_inc;
                o_upd.deq    = (w_inc <= 0) && (i_req.len != '0);
            end
        end
    end

endmodule

### rtl/counting_semaphore_wait_queue.sv
// Bank of counting semaphores, each with a FIFO queue of waiting process ids.
// A P beat (op 0) decrements the addressed count and, if it goes negative,
// pushes the caller onto that semaphore's queue and reports it blocked. A V
// beat (op 1) increments the count and, if it is then zero or below, pops the
// oldest waiter and reports it in woken_id. A push into a full queue or a step
// past the count range -16..15 is refused with a status code and leaves the
// state unchanged. A request is accepted in S_IDLE, which launches a read of
// the count memory and of the queue memory at the queue head; in S_EXEC the
// commit writes the updated count and any pushed id back and loads the result
// register once that register is free or being drained. The input side stalls
// while a request is in flight, so a new beat is taken only after the last one
// commits. Writing init_count_k stores the value, reloads count k from it and
// empties queue k; the port is always ready and is meant to be written only
// while no request is in flight. After reset the counts read as their init
// registers through per-entry valid bits, so no clearing pass is needed. Queue
// entries are never popped before being written.
// Depends on csq_pkg, csq_ram and csq_alu.
module counting_semaphore_wait_queue import csq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [SEM_IN_W-1:0] i_sem_index,
    input  logic [ID_W-1:0]     i_caller_id,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_blocked,
    output logic                o_woken_valid,
    output logic [ID_W-1:0]     o_woken_id,
    output logic signed [COUNT_W-1:0] o_new_count,
    output logic [STATUS_W-1:0] o_status,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [INIT_W-1:0]   i_cfg_data
);

    t_state r_state, n_state;
    t_req   r_req;
    t_upd   w_upd;

    logic [INIT_W-1:0] r_init    [NUM_INIT_REGS];
    logic              r_cnt_vld [NUM_SEMAPHORES];
    logic [HEAD_W-1:0] r_head    [NUM_SEMAPHORES];
    logic [LEN_W-1:0]  r_len     [NUM_SEMAPHORES];

    logic                r_out_valid;
    logic                r_blocked;
    logic                r_woken_valid;
    logic [ID_W-1:0]     r_woken_id;
    logic signed [COUNT_W-1:0] r_new_count;
    logic [STATUS_W-1:0] r_status;

    logic                in_acc;
    logic                commit;
    logic                cfg_wr;
    logic                cfg_sem_hit;
    logic [SEM_W-1:0]    in_sem;
    logic [SEM_W-1:0]    cfg_sem;
    logic                in_absent;

    logic [COUNT_W-1:0]  cnt_rdata;
    logic [INIT_W-1:0]   w_init;
    logic signed [COUNT_W-1:0] w_count;
    logic [ID_W-1:0]     q_rdata;
    logic [QADDR_W-1:0]  q_raddr;
    logic [QADDR_W-1:0]  q_waddr;
    logic [LEN_W:0]      slot_sum;
    logic [HEAD_W-1:0]   tail_slot;
    logic [HEAD_W-1:0]   next_head;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Finish only once the result register is free or being drained.
    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign in_sem      = SEM_W'(i_sem_index);
    assign in_absent   = (int'(i_sem_index) >= NUM_SEMAPHORES);
    assign cfg_sem     = SEM_W'(i_cfg_index);
    assign cfg_sem_hit = (int'(i_cfg_index) < NUM_SEMAPHORES);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Capture the request with its queue head and length at accept.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.absent <= in_absent;
            r_req.op     <= i_op;
            r_req.sem    <= in_sem;
            r_req.caller <= i_caller_id;
            r_req.head   <= r_head[in_sem];
            r_req.len    <= r_len[in_sem];
        end
    end

    // ------------------------------------------------------------------
    // count memory; an entry without its valid bit reads as its init value
    // ------------------------------------------------------------------
    csq_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_SEMAPHORES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (commit && w_upd.cnt_we),
        .i_waddr (r_req.sem),
        .i_wdata (w_upd.cnt),
        .i_re    (in_acc),
        .i_raddr (in_sem),
        .o_rdata (cnt_rdata)
    );

    always_comb begin
        w_init = '0;
        for (int k = 0; k < NUM_INIT_REGS; k++) begin
            if (k == int'(r_req.sem)) begin
                w_init = r_init[k];
            end
        end
    end

    assign w_count = r_cnt_vld[r_req.sem] ? $signed(cnt_rdata)
                                          : $signed({1'b0, w_init});

    // ------------------------------------------------------------------
    // wait queue memory: one ring of QUEUE_DEPTH ids per semaphore
    // ------------------------------------------------------------------
    assign q_raddr = QADDR_W'(in_sem) * QADDR_W'(QUEUE_DEPTH)
                   + QADDR_W'(r_head[in_sem]);

    // Tail slot wraps once at most: head stays below the depth and length never exceeds it.
    assign slot_sum  = (LEN_W + 1)'(r_req.head) + (LEN_W + 1)'(r_req.len);
    assign tail_slot = (slot_sum >= (LEN_W + 1)'(QUEUE_DEPTH))
                     ? HEAD_W'(slot_sum - (LEN_W + 1)'(QUEUE_DEPTH))
                     : HEAD_W'(slot_sum);
    assign next_head = (r_req.head == HEAD_W'(QUEUE_DEPTH - 1))
                     ? '0 : r_req.head + HEAD_W'(1);

    assign q_waddr = QADDR_W'(r_req.sem) * QADDR_W'(QUEUE_DEPTH)
                   + QADDR_W'(tail_slot);

    csq_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_SEMAPHORES * QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (commit && w_upd.enq),
        .i_waddr (q_waddr),
        .i_wdata (r_req.caller),
        .i_re    (in_acc),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // ------------------------------------------------------------------
    // decision
    // ------------------------------------------------------------------
    csq_alu u_alu (
        .i_req   (r_req),
        .i_count (w_count),
        .o_upd   (w_upd)
    );

    // ------------------------------------------------------------------
    // per-semaphore control state and init registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_INIT_REGS; k++) begin
                r_init[k] <= init_reset_value(k);
            end
            for (int k = 0; k < NUM_SEMAPHORES; k++) begin
                r_cnt_vld[k] <= 1'b0;
                r_head[k]    <= '0;
                r_len[k]     <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_init[i_cfg_index] <= i_cfg_data;
                // Reload: drop the stored count and empty the queue.
                if (cfg_sem_hit) begin
                    r_cnt_vld[cfg_sem] <= 1'b0;
                    r_head[cfg_sem]    <= '0;
                    r_len[cfg_sem]     <= '0;
                end
            end
            if (commit && w_upd.cnt_we) begin
                r_cnt_vld[r_req.sem] <= 1'b1;
            end
            if (commit && w_upd.enq) begin
                r_len[r_req.sem] <= r_req.len + LEN_W'(1);
            end
            if (commit && w_upd.deq) begin
                r_len[r_req.sem]  <= r_req.len - LEN_W'(1);
                r_head[r_req.sem] <= next_head;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_blocked     <= w_upd.blocked;
            r_woken_valid <= w_upd.deq;
            r_woken_id    <= w_upd.deq ? q_rdata : '0;
            r_new_count   <= w_upd.cnt;
            r_status      <= w_upd.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_blocked     = r_blocked;
    assign o_woken_valid = r_woken_valid;
    assign o_woken_id    = r_woken_id;
    assign o_new_count   = r_new_count;
    assign o_status      = r_status;

endmodule

### rtl/csq_checker.sv
// Port-level checker for the semaphore bank, bound to the top level.
// Depends on csq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csq_checker import csq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_blocked,
    input logic                o_woken_valid,
    input logic [ID_W-1:0]     o_woken_id,
    input logic signed [COUNT_W-1:0] o_new_count,
    input logic [STATUS_W-1:0] o_status
);

    logic in_beat;
    logic out_hold;
    logic blk_ok;
    logic wake_ok;
    logic [ID_W+COUNT_W+STATUS_W+1:0] out_word;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;
    assign blk_ok   = (o_status == STATUS_OK) && !o_woken_valid && o_new_count[COUNT_W-1];
    assign wake_ok  = (o_status == STATUS_OK)
                   && (o_new_count[COUNT_W-1] || (o_new_count == '0));
    assign out_word = {o_blocked, o_woken_valid, o_woken_id, o_new_count, o_status};

    // An accepted request is followed by a stalled input side.
    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, o_in_stall)

    // A blocked caller means a clean push and a negative count.
    `AST_SAME(a_blocked_clean, i_clk, i_rst_n, o_out_valid && o_blocked, blk_ok)

    // A wake-up only happens at count zero or below, and only when ok.
    `AST_SAME(a_wake_count, i_clk, i_rst_n, o_out_valid && o_woken_valid, wake_ok)

    // No released id without a wake-up.
    `AST_SAME(a_woken_id_zero, i_clk, i_rst_n, o_out_valid && !o_woken_valid, o_woken_id == '0)

    // A stalled result holds.
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(out_word))

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (.*);
